FILE: hdl/vgapm_pkg.sv
// Shared types and constants for the planar video memory access block.
// No dependencies.
`default_nettype none

package vgapm_pkg;

	localparam int REG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_MAP_SELECT       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHAIN_FOUR       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE_SELECT      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROTATE_OP        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SET_RESET_CTL    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PIX_MASK         = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_READ_PLANE       = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_WRITE_MASK = 3'd7;

	// Memory map windows
	localparam logic [1:0] MAP_A0_128K = 2'd0;
	localparam logic [1:0] MAP_A0_64K  = 2'd1;
	localparam logic [1:0] MAP_B0_32K  = 2'd2;
	localparam logic [1:0] MAP_B8_32K  = 2'd3;

	localparam logic [19:0] WIN_A0000 = 20'ha0000;
	localparam logic [19:0] WIN_AFFFF = 20'haffff;
	localparam logic [19:0] WIN_B0000 = 20'hb0000;
	localparam logic [19:0] WIN_B7FFF = 20'hb7fff;
	localparam logic [19:0] WIN_B8000 = 20'hb8000;
	localparam logic [19:0] WIN_BFFFF = 20'hbffff;

	// Write modes
	localparam logic [1:0] WMODE_0 = 2'd0;
	localparam logic [1:0] WMODE_1 = 2'd1;
	localparam logic [1:0] WMODE_2 = 2'd2;
	localparam logic [1:0] WMODE_3 = 2'd3;

	// Logic ops
	localparam logic [1:0] LOP_NONE = 2'd0;
	localparam logic [1:0] LOP_AND  = 2'd1;
	localparam logic [1:0] LOP_OR   = 2'd2;
	localparam logic [1:0] LOP_XOR  = 2'd3;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [7:0] OUT_OF_WINDOW_READ = 8'hff;

	typedef struct packed {
		logic        op;
		logic [19:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       unsupported;
	} rsp_t;

	typedef struct packed {
		logic [1:0] map_select;
		logic       chain_four;
		logic [3:0] mode_select;
		logic [4:0] rotate_op;
		logic [7:0] set_reset_ctl;
		logic [7:0] pix_mask;
		logic [1:0] read_plane;
		logic [3:0] plane_write_mask;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		map_select:       MAP_B0_32K,
		chain_four:       1'b0,
		mode_select:      4'd0,
		rotate_op:        5'd0,
		set_reset_ctl:    8'd0,
		pix_mask:         8'd0,
		read_plane:       2'd0,
		plane_write_mask: 4'hf
	};

	function automatic logic [7:0] combine(input logic [7:0] a, input logic [7:0] b,
			input logic [1:0] lop);
		logic [7:0] r;
		case (lop)
			LOP_AND: r = a & b;
			LOP_OR:  r = a | b;
			LOP_XOR: r = a ^ b;
			default: r = a;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/vgapm_plane_ram.sv
// Plane store: one word per offset, four byte lanes (one per plane), byte
// write enables, registered read. Clears itself after reset. Uses vgapm_pkg.
`default_nettype none

module vgapm_plane_ram #(
	parameter int PLANE_DEPTH = 65536,
	parameter int AW          = $clog2(PLANE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [3:0]    wr_en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [31:0]   wdata,
	output logic      [31:0]   rdata,
	output logic               clearing
);
	import vgapm_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(PLANE_DEPTH - 1);

	logic [31:0]   mem [PLANE_DEPTH];
	logic [31:0]   rdata_q;
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	logic [AW-1:0] waddr;
	logic [3:0]    wen;
	logic [31:0]   wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST)
				clearing_q <= 1'b0;
		end
	end

	always_comb begin
		if (clearing_q) begin
			waddr = clr_cnt_q;
			wen   = 4'hf;
			wd    = '0;
		end else begin
			waddr = addr;
			wen   = wr_en;
			wd    = wdata;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < 4; p++) begin
			if (wen[p])
				mem[waddr][8*p +: 8] <= wd[8*p +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en && !clearing_q)
			rdata_q <= mem[addr];
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

FILE: hdl/vgapm_write_unit.sv
// Planar write datapath: rotate, set/reset, logic op and bit mask per plane.
// Uses vgapm_pkg.
`default_nettype none

module vgapm_write_unit (
	input  wire vgapm_pkg::cfg_t cfg,
	input  wire logic [7:0]  data,
	input  wire logic [31:0] latches,
	output logic      [31:0] word,
	output logic             refused
);
	import vgapm_pkg::*;

	logic [1:0] wmode;
	logic [2:0] rot;
	logic [1:0] lop;
	logic [7:0] bm;
	logic [3:0] sr;
	logic [3:0] esr;
	logic [7:0] val;

	assign wmode   = cfg.mode_select[1:0];
	assign rot     = cfg.rotate_op[2:0];
	assign lop     = cfg.rotate_op[4:3];
	assign bm      = cfg.pix_mask;
	assign sr      = cfg.set_reset_ctl[3:0];
	assign esr     = cfg.set_reset_ctl[7:4];
	assign val     = 8'({data, data} >> rot);
	assign refused = (wmode == WMODE_2) && (lop != LOP_NONE);

	always_comb begin
		logic [7:0] l;
		logic [7:0] nv;
		word = '0;
		for (int p = 0; p < 4; p++) begin
			l  = latches[8*p +: 8];
			nv = l & ~bm;
			case (wmode)
				WMODE_0: begin
					if (esr[p]) begin
						if (lop == LOP_NONE)
							nv = nv | (sr[p] ? bm : 8'h00);
						else
							nv = nv | ((sr[p] ? ~l : l) & bm);
					end else begin
						nv = nv | (combine(val & bm, l, lop) & bm);
					end
				end
				WMODE_1: nv = l;
				WMODE_2: nv = nv | (data[p] ? bm : 8'h00);
				default: nv = nv | combine(sr[p] ? data : 8'h00, l, lop);
			endcase
			word[8*p +: 8] = nv;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/vga_planar_memory_access.sv
// Top level of the planar video memory access block: window decode, latches,
// result stage. Uses vgapm_pkg, vgapm_plane_ram and vgapm_write_unit.
//
// Usage: a CPU byte access (req: op, address, write_data) is taken at a rising
// edge with start high and busy low. Its result word (rsp: read_data,
// unsupported) appears in the next cycle with done high for exactly that cycle;
// the receiver cannot stall, so the word must be taken then.
// Latency is one cycle and a new access may be taken every cycle: the plane
// memory has one port with one-cycle read latency, and a planar write that
// directly follows a planar read gets the freshly read word as its latches.
// Configuration is written through cfg_we / cfg_index / cfg_wdata, one register
// per cycle, only while no access is in flight: the user's duty, not enforced.
// After reset, busy stays high while the plane memory is swept to zero, one word
// per cycle; configuration writes are taken meanwhile.
// Reset also loads the register defaults and clears the latches.
`default_nettype none

module vga_planar_memory_access #(
	parameter int PLANE_DEPTH = 65536
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire vgapm_pkg::req_t                   req,
	output logic                                   done,
	output vgapm_pkg::rsp_t                        rsp,
	input  wire logic                              cfg_we,
	input  wire logic [vgapm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [7:0]                        cfg_wdata
);
	import vgapm_pkg::*;

	localparam int AW = $clog2(PLANE_DEPTH);
	localparam logic [17:0] D1 = 18'(PLANE_DEPTH);
	localparam logic [17:0] D2 = 18'(2 * PLANE_DEPTH);
	localparam logic [17:0] D3 = 18'(3 * PLANE_DEPTH);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_SELECT:       cfg_q.map_select       <= cfg_wdata[1:0];
				REG_CHAIN_FOUR:       cfg_q.chain_four       <= cfg_wdata[0];
				REG_MODE_SELECT:      cfg_q.mode_select      <= cfg_wdata[3:0];
				REG_ROTATE_OP:        cfg_q.rotate_op        <= cfg_wdata[4:0];
				REG_SET_RESET_CTL:    cfg_q.set_reset_ctl    <= cfg_wdata;
				REG_PIX_MASK:         cfg_q.pix_mask         <= cfg_wdata;
				REG_READ_PLANE:       cfg_q.read_plane       <= cfg_wdata[1:0];
				REG_PLANE_WRITE_MASK: cfg_q.plane_write_mask <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Window decode
	logic [19:0] lo, hi;
	logic        in_win;
	logic [16:0] off_raw;
	logic [17:0] off_x;
	logic [17:0] off_mod;
	logic [AW-1:0] off;

	always_comb begin
		unique case (cfg_q.map_select)
			MAP_A0_128K: begin lo = WIN_A0000; hi = WIN_BFFFF; end
			MAP_A0_64K:  begin lo = WIN_A0000; hi = WIN_AFFFF; end
			MAP_B0_32K:  begin lo = WIN_B0000; hi = WIN_B7FFF; end
			default:     begin lo = WIN_B8000; hi = WIN_BFFFF; end
		endcase
	end

	assign in_win  = (req.address >= lo) && (req.address <= hi);
	assign off_raw = 17'(req.address - lo);
	assign off_x   = {1'b0, off_raw};

	// offset < 2^17 and depth >= 2^15, so at most three subtractions of depth
	always_comb begin
		if (off_x >= D3)
			off_mod = off_x - D3;
		else if (off_x >= D2)
			off_mod = off_x - D2;
		else if (off_x >= D1)
			off_mod = off_x - D1;
		else
			off_mod = off_x;
	end
	assign off = AW'(off_mod);

	// Access control
	logic        accept;
	logic        clearing;
	logic        is_wr;
	logic        chain;
	logic        rd_refused;
	logic        wr_refused;
	logic [31:0] rdata;
	logic [31:0] latches_q;
	logic [31:0] latches_eff;
	logic [31:0] planar_word;
	logic        mem_rd;
	logic [3:0]  mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0] mem_wdata;
	logic [1:0]  c4_plane;

	logic        valid_s1;
	logic        rd_mem_s1;
	logic        load_s1;
	logic        flag_s1;
	logic [1:0]  lane_s1;
	logic [7:0]  rd_const_s1;

	assign busy     = clearing;
	assign accept   = start && !busy;
	assign is_wr    = (req.op == OP_WRITE);
	assign chain    = cfg_q.chain_four;
	assign c4_plane = off[1:0];

	// latches loaded by the read just before are forwarded from the memory output
	assign latches_eff = (valid_s1 && load_s1) ? rdata : latches_q;

	vgapm_write_unit u_write (
		.cfg     (cfg_q),
		.data    (req.write_data),
		.latches (latches_eff),
		.word    (planar_word),
		.refused (wr_refused)
	);

	assign rd_refused = cfg_q.mode_select[3];

	always_comb begin
		mem_rd    = 1'b0;
		mem_we    = 4'h0;
		mem_addr  = off;
		mem_wdata = planar_word;
		if (accept && in_win) begin
			if (chain) begin
				mem_addr  = {off[AW-1:2], 2'b00};
				mem_wdata = {4{req.write_data}};
				if (is_wr)
					mem_we = 4'b0001 << c4_plane;
				else
					mem_rd = 1'b1;
			end else if (is_wr) begin
				if (!wr_refused)
					mem_we = cfg_q.plane_write_mask;
			end else if (!rd_refused) begin
				mem_rd = 1'b1;
			end
		end
	end

	vgapm_plane_ram #(
		.PLANE_DEPTH (PLANE_DEPTH),
		.AW          (AW)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (mem_rd),
		.wr_en    (mem_we),
		.addr     (mem_addr),
		.wdata    (mem_wdata),
		.rdata    (rdata),
		.clearing (clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			load_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			load_s1  <= accept && in_win && !chain && !is_wr && !rd_refused;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_mem_s1   <= mem_rd;
			lane_s1     <= chain ? c4_plane : cfg_q.read_plane;
			flag_s1     <= in_win && !chain && (is_wr ? wr_refused : rd_refused);
			rd_const_s1 <= (!in_win && !is_wr) ? OUT_OF_WINDOW_READ : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			latches_q <= '0;
		else if (valid_s1 && load_s1)
			latches_q <= rdata;
	end

	always_comb begin
		done            = valid_s1;
		rsp.read_data   = 8'h00;
		rsp.unsupported = 1'b0;
		if (valid_s1) begin
			rsp.read_data   = rd_mem_s1 ? 8'(rdata >> {lane_s1, 3'b000}) : rd_const_s1;
			rsp.unsupported = flag_s1;
		end
	end

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result word without an accepted access");

	a_refused_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.unsupported) |-> (rsp.read_data == 8'h00))
		else $error("refused access returned data");

	a_latch_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(latches_q != $past(latches_q)) |-> $past(valid_s1 && load_s1))
		else $error("latches changed without a planar read");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |=> !done || !$past(clearing))
		else $error("access taken during memory clear");

endmodule

`default_nettype wire

FILE: dv/vga_planar_memory_access_test.sv
// Self-checking testbench for vga_planar_memory_access: directed and random CPU byte
// accesses, checked word by word against a planar memory predictor.
// Depends on hdl/vgapm_pkg.sv and the block's RTL.
`default_nettype none

module vga_planar_memory_access_test;

	import vgapm_pkg::*;

	localparam int PLANE_DEPTH = 65536;
	localparam int RANDOM_ITEMS = 1450;
	localparam logic [7:0] READ_MODE_1 = 8'h08;

	typedef enum logic [1:0] {STEP_ACCESS, STEP_CFG, STEP_DRAIN} step_kind_t;

	typedef struct packed {
		step_kind_t              kind;
		req_t                    word;
		logic [REG_IDX_W-1:0]    idx;
		logic [7:0]              val;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	req_t                 req = '0;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_wdata = '0;

	// predictor state
	logic [31:0] plane_mem [PLANE_DEPTH];
	logic [31:0] latches = '0;
	cfg_t        cur_cfg = CFG_RESET;

	step_t steps[$];
	rsp_t  due_rsp[$];
	logic  took_word = 1'b0;
	int    burst_left = 0;
	int    gap_left = 0;
	int    err_count = 0;

	vga_planar_memory_access #(.PLANE_DEPTH(PLANE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void window_bounds(input logic [1:0] map, output logic [19:0] lo,
			output logic [19:0] hi);
		case (map)
			MAP_A0_128K: begin
				lo = WIN_A0000;
				hi = WIN_BFFFF;
			end
			MAP_A0_64K: begin
				lo = WIN_A0000;
				hi = WIN_AFFFF;
			end
			MAP_B0_32K: begin
				lo = WIN_B0000;
				hi = WIN_B7FFF;
			end
			default: begin
				lo = WIN_B8000;
				hi = WIN_BFFFF;
			end
		endcase
	endfunction

	function automatic logic [7:0] apply_lop(input logic [7:0] a, input logic [7:0] b,
			input logic [1:0] lop);
		case (lop)
			LOP_AND: return a & b;
			LOP_OR:  return a | b;
			LOP_XOR: return a ^ b;
			default: return a;
		endcase
	endfunction

	// One CPU byte access against the predicted planes; returns the result word.
	function automatic rsp_t vga_byte_access(input req_t w);
		rsp_t        r;
		logic [19:0] lo, hi, diff;
		logic [15:0] offs, idx;
		logic [1:0]  wmode, lop, lane;
		logic [2:0]  rot;
		logic [3:0]  sr, esr;
		logic [7:0]  bm, val, lat, nv;
		logic [15:0] dbl;
		logic [31:0] word;
		int          p;
		r = '0;
		window_bounds(cur_cfg.map_select, lo, hi);
		diff = w.address - lo;
		offs = diff[15:0];
		if (w.address < lo || w.address > hi) begin
			r.read_data = (w.op == OP_WRITE) ? 8'h00 : OUT_OF_WINDOW_READ;
		end else if (cur_cfg.chain_four) begin
			lane = offs[1:0];
			idx = {offs[15:2], 2'b00};
			word = plane_mem[idx];
			if (w.op == OP_WRITE) begin
				word[lane*8 +: 8] = w.write_data;
				plane_mem[idx] = word;
			end else begin
				r.read_data = word[lane*8 +: 8];
			end
		end else if (w.op == OP_READ) begin
			if (cur_cfg.mode_select[3]) begin
				r.unsupported = 1'b1;
			end else begin
				latches = plane_mem[offs];
				r.read_data = latches[cur_cfg.read_plane*8 +: 8];
			end
		end else begin
			wmode = cur_cfg.mode_select[1:0];
			rot = cur_cfg.rotate_op[2:0];
			lop = cur_cfg.rotate_op[4:3];
			bm = cur_cfg.pix_mask;
			sr = cur_cfg.set_reset_ctl[3:0];
			esr = cur_cfg.set_reset_ctl[7:4];
			if (wmode == WMODE_2 && lop != LOP_NONE) begin
				r.unsupported = 1'b1;
			end else begin
				dbl = {w.write_data, w.write_data} >> rot;
				val = dbl[7:0];
				word = plane_mem[offs];
				for (p = 0; p < 4; p++) begin
					lat = latches[p*8 +: 8];
					nv = lat & ~bm;
					case (wmode)
						WMODE_0: begin
							if (esr[p]) begin
								if (lop == LOP_NONE)
									nv |= sr[p] ? bm : 8'h00;
								else
									nv |= (sr[p] ? ~lat : lat) & bm;
							end else begin
								nv |= apply_lop(val & bm, lat, lop) & bm;
							end
						end
						WMODE_1: nv = lat;
						WMODE_2: nv |= w.write_data[p] ? bm : 8'h00;
						default: nv |= apply_lop(sr[p] ? w.write_data : 8'h00, lat, lop);
					endcase
					if (cur_cfg.plane_write_mask[p])
						word[p*8 +: 8] = nv;
				end
				plane_mem[offs] = word;
			end
		end
		return r;
	endfunction

	// Address inside the current window, clustered so that reads hit written words.
	function automatic logic [19:0] pick_addr(input logic [1:0] map);
		logic [19:0] lo, hi, span, offs;
		window_bounds(map, lo, hi);
		span = hi - lo + 20'd1;
		offs = 20'($urandom_range(0, 15));
		case ($urandom_range(0, 4))
			0: offs = span - 20'd1 - offs;
			1: offs = (offs + 20'h10000) % span;   // aliases low offsets in the 128K map
			2: offs = 20'($urandom()) % span;
			default: ;
		endcase
		return lo + offs;
	endfunction

	// Half extremes (00 or ff), half random; full byte so that dropped upper bits get exercised.
	function automatic logic [7:0] skewed_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic push_access(input logic op, input logic [19:0] addr, input logic [7:0] data);
		step_t s;
		s = '0;
		s.kind = STEP_ACCESS;
		s.word.op = op;
		s.word.address = addr;
		s.word.write_data = data;
		steps.push_back(s);
	endtask

	task automatic push_cfg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
		step_t s;
		s = '0;
		s.kind = STEP_CFG;
		s.idx = idx;
		s.val = val;
		steps.push_back(s);
	endtask

	task automatic push_drain();
		step_t s;
		s = '0;
		s.kind = STEP_DRAIN;
		steps.push_back(s);
	endtask

	task automatic note_fail(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Driver: one word per step, bursts with gaps; config only when nothing is due.
	always @(negedge clk) begin : drive
		logic go, wr;
		go = 1'b0;
		wr = 1'b0;
		if (arst_n && !(start && !took_word)) begin
			if (steps.size() != 0) begin
				case (steps[0].kind)
					STEP_ACCESS: begin
						if (gap_left > 0) begin
							gap_left = gap_left - 1;
						end else begin
							req <= steps[0].word;
							steps.delete(0);
							go = 1'b1;
							burst_left = burst_left - 1;
							if (burst_left <= 0) begin
								burst_left = ($urandom_range(0, 7) == 0) ?
									$urandom_range(100, 300) : $urandom_range(1, 24);
								gap_left = ($urandom_range(0, 7) == 0) ?
									$urandom_range(15, 30) : $urandom_range(0, 6);
							end
						end
					end
					STEP_CFG: begin
						if (due_rsp.size() == 0 && !took_word) begin
							cfg_index <= steps[0].idx;
							cfg_wdata <= steps[0].val;
							wr = 1'b1;
							steps.delete(0);
						end
					end
					default: begin
						if (due_rsp.size() == 0 && !took_word)
							steps.delete(0);
					end
				endcase
			end
			start <= go;
			cfg_we <= wr;
		end
	end

	// Monitor: check the result word, track config writes, predict accepted words.
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			took_word <= start && !busy;
			if (done) begin
				if (due_rsp.size() == 0) begin
					note_fail($sformatf("unexpected result read_data=%02h unsupported=%0b",
						rsp.read_data, rsp.unsupported));
				end else begin
					want = due_rsp.pop_front();
					if (rsp.read_data !== want.read_data)
						note_fail($sformatf("read_data exp %02h got %02h",
							want.read_data, rsp.read_data));
					if (rsp.unsupported !== want.unsupported)
						note_fail($sformatf("unsupported exp %0b got %0b",
							want.unsupported, rsp.unsupported));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MAP_SELECT:       cur_cfg.map_select = cfg_wdata[1:0];
					REG_CHAIN_FOUR:       cur_cfg.chain_four = cfg_wdata[0];
					REG_MODE_SELECT:      cur_cfg.mode_select = cfg_wdata[3:0];
					REG_ROTATE_OP:        cur_cfg.rotate_op = cfg_wdata[4:0];
					REG_SET_RESET_CTL:    cur_cfg.set_reset_ctl = cfg_wdata;
					REG_PIX_MASK:         cur_cfg.pix_mask = cfg_wdata;
					REG_READ_PLANE:       cur_cfg.read_plane = cfg_wdata[1:0];
					default:              cur_cfg.plane_write_mask = cfg_wdata[3:0];
				endcase
			end
			if (start && !busy)
				due_rsp.push_back(vga_byte_access(req));
		end
	end

	initial begin : stimulus
		logic [1:0]  gen_map;
		logic [7:0]  map_v;
		logic [19:0] a, b;
		int          n_items, n_here, phase_len, nw;

		foreach (plane_mem[i])
			plane_mem[i] = '0;

		// reset settings: B0000 window, planar, write mode 0, bit mask clear
		push_access(OP_READ, WIN_B0000, 8'hff);
		push_access(OP_READ, WIN_B7FFF, 8'h00);
		push_access(OP_READ, WIN_AFFFF, 8'h00);
		push_access(OP_READ, WIN_B8000, 8'h00);
		push_access(OP_READ, 20'hfffff, 8'h00);
		push_access(OP_WRITE, 20'h00000, 8'hff);
		push_access(OP_WRITE, WIN_B0000, 8'hff);
		push_cfg(REG_PIX_MASK, 8'hff);
		push_access(OP_WRITE, WIN_B0000, 8'ha5);
		push_access(OP_READ, WIN_B0000, 8'h00);
		push_cfg(REG_ROTATE_OP, {3'd0, LOP_XOR, 3'd3});
		push_cfg(REG_SET_RESET_CTL, 8'hc5);
		push_access(OP_WRITE, WIN_B0000 + 20'd1, 8'hff);
		push_cfg(REG_ROTATE_OP, {3'd0, LOP_NONE, 3'd7});
		push_access(OP_WRITE, WIN_B0000 + 20'd2, 8'h81);
		push_cfg(REG_MODE_SELECT, {6'd0, WMODE_1});
		push_access(OP_READ, WIN_B0000, 8'h00);
		push_access(OP_WRITE, WIN_B0000 + 20'd3, 8'h00);
		push_cfg(REG_MODE_SELECT, {6'd0, WMODE_2});
		push_cfg(REG_ROTATE_OP, {3'd0, LOP_NONE, 3'd0});
		push_cfg(REG_PIX_MASK, 8'h3c);
		push_access(OP_WRITE, WIN_B0000 + 20'd4, 8'h0a);
		push_cfg(REG_ROTATE_OP, {3'd0, LOP_AND, 3'd0});
		push_access(OP_WRITE, WIN_B0000 + 20'd5, 8'h0a);   // mode 2 with an op: refused
		push_cfg(REG_MODE_SELECT, {6'd0, WMODE_3});
		push_cfg(REG_ROTATE_OP, {3'd0, LOP_OR, 3'd5});
		push_cfg(REG_SET_RESET_CTL, 8'h0a);
		push_access(OP_WRITE, WIN_B0000 + 20'd6, 8'h3c);
		push_access(OP_READ, WIN_B0000 + 20'd6, 8'h00);
		push_cfg(REG_MODE_SELECT, READ_MODE_1);
		push_access(OP_READ, WIN_B0000, 8'h00);              // refused
		push_access(OP_WRITE, WIN_B7FFF, 8'h77);
		push_cfg(REG_CHAIN_FOUR, 8'h01);
		push_cfg(REG_MAP_SELECT, {6'd0, MAP_A0_128K});
		push_access(OP_WRITE, WIN_BFFFF, 8'h5a);             // wraps onto AFFFF
		push_access(OP_READ, WIN_AFFFF, 8'h00);
		push_access(OP_READ, WIN_A0000 + 20'd1, 8'h00);
		push_cfg(REG_CHAIN_FOUR, 8'hfe);                     // upper bits dropped
		push_cfg(REG_MAP_SELECT, {6'd0, MAP_A0_64K});
		push_cfg(REG_READ_PLANE, 8'h03);
		push_cfg(REG_PLANE_WRITE_MASK, 8'h00);
		push_cfg(REG_MODE_SELECT, 8'h00);
		push_access(OP_READ, WIN_A0000, 8'h00);
		push_access(OP_WRITE, WIN_A0000, 8'hff);
		push_cfg(REG_MAP_SELECT, {6'd0, MAP_B8_32K});
		push_cfg(REG_PLANE_WRITE_MASK, 8'h0f);
		push_access(OP_READ, WIN_B8000, 8'h00);
		push_access(OP_READ, WIN_BFFFF, 8'h00);
		push_access(OP_READ, WIN_B7FFF, 8'h00);

		// random phases: fresh settings, then read/modify/read sequences plus noise
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			map_v = skewed_byte();
			gen_map = map_v[1:0];
			push_cfg(REG_MAP_SELECT, map_v);
			push_cfg(REG_CHAIN_FOUR, ($urandom_range(0, 3) == 0) ? skewed_byte() : 8'h00);
			push_cfg(REG_MODE_SELECT, skewed_byte() & (($urandom_range(0, 3) == 0) ?
				8'hff : 8'hf7));
			push_cfg(REG_ROTATE_OP, skewed_byte());
			push_cfg(REG_SET_RESET_CTL, skewed_byte());
			push_cfg(REG_PIX_MASK, skewed_byte());
			push_cfg(REG_READ_PLANE, skewed_byte());
			push_cfg(REG_PLANE_WRITE_MASK, skewed_byte());
			phase_len = $urandom_range(15, 70);
			n_here = 0;
			while (n_here < phase_len) begin
				if ($urandom_range(0, 39) == 0)
					push_drain();
				if ($urandom_range(0, 4) == 0) begin
					push_access(1'($urandom()), 20'($urandom()), 8'($urandom()));
					n_here += 1;
				end else begin
					a = pick_addr(gen_map);
					b = a;
					push_access(OP_READ, a, 8'($urandom()));
					nw = $urandom_range(1, 3);
					repeat (nw) begin
						b = ($urandom_range(0, 1) == 0) ? a : pick_addr(gen_map);
						push_access(OP_WRITE, b, 8'($urandom()));
					end
					push_access(OP_READ, b, 8'($urandom()));
					n_here += nw + 2;
				end
			end
			n_items += n_here;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (steps.size() != 0 || start || took_word || due_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (err_count == 0 && due_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hdl/vgapm_pkg.sv
hdl/vgapm_plane_ram.sv
hdl/vgapm_write_unit.sv
hdl/vga_planar_memory_access.sv
dv/vga_planar_memory_access_test.sv
